[rtl/core/tlik_pkg.sv]
// Shared types, widths and constants for the two-link planar IK pipeline.
`default_nettype none
package tlik_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

  localparam int IN_W      = 16;
  localparam int LEN_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_W      = 31;
  localparam int LSQ_W     = 2 * LEN_W;
  localparam int R2_W      = 32;
  localparam int BOT_W     = 29;
  localparam int TOPR_W    = 33;
  localparam int TOP_W     = 30;
  localparam int PROD_W    = 2 * TOP_W;
  localparam int RAD_W     = 58;
  localparam int SQRT_W    = 29;
  localparam int NUM_W     = LEN_W + SQRT_W;
  localparam int P1_W      = LEN_W + BOT_W + 1;
  localparam int P2_W      = LEN_W + 1 + TOP_W;
  localparam int DEN_W     = P2_W + 1;

  localparam int VEC_W      = 53;
  localparam int ANG_W      = 34;
  localparam int NORM_BIT   = 48;
  localparam int NORM_STEPS = 6;
  localparam int VEC_LAT    = 1 + NORM_STEPS + CORDIC_STAGES;

  localparam logic signed [ANG_W-1:0] HALF_PI    = 34'sd1686629713;
  localparam logic signed [ANG_W:0]   ROUND_HALF = (ANG_W + 1)'(1) << (ANG_SHIFT - 1);
  localparam logic signed [ANG_W:0]   ELBOW_MAX  = 35'sd32767;
  localparam logic signed [ANG_W:0]   SHLD_MAX   = 35'sd32767;
  localparam logic signed [ANG_W:0]   SHLD_MIN   = -35'sd32768;

  localparam logic [LEN_W-1:0] L1_RESET = 14'd7680;
  localparam logic [LEN_W-1:0] L2_RESET = 14'd10240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1
  } tlik_reg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] target_x;
    logic signed [IN_W-1:0] target_y;
  } tlik_in_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic [14:0]        elbow_angle;
    logic               unreachable;
  } tlik_out_t;

  typedef struct packed {
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [TOP_W-1:0] top;
    logic [BOT_W-1:0]        bottom;
    logic                    unreach;
  } tlik_side_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/tlik_front.sv]
// Front end: squares, law-of-cosines terms, ratio clamp and sqrt radicand.
`default_nettype none
module tlik_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  tlik_pkg::tlik_in_t           in_data,
  input  logic [tlik_pkg::LEN_W-1:0]   l1,
  input  logic [tlik_pkg::LEN_W-1:0]   l2,
  output logic                         out_valid,
  output logic [tlik_pkg::RAD_W-1:0]   out_rad,
  output tlik_pkg::tlik_side_t         out_side
);
  import tlik_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [IN_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [SQ_W-1:0]   xx1_r, yy1_r, xx1_nxt, yy1_nxt;
  logic [LSQ_W-1:0]  l1sq1_r, l2sq1_r, l12_1_r, l1sq1_nxt, l2sq1_nxt, l12_1_nxt;
  logic [R2_W-1:0]   r2_2_r, r2_2_nxt;
  logic [BOT_W-1:0]  ll2_r, bot2_r, bot3_r, ll2_nxt, bot2_nxt;
  logic signed [TOPR_W-1:0] top3_r, top3_nxt, bnd;
  tlik_side_t        side4_r, side5_r, side6_r, side4_nxt;
  logic [TOP_W-1:0]  bm5_r, bp5_r, bm5_nxt, bp5_nxt;
  logic [RAD_W-1:0]  rad6_r, rad6_nxt;

  always_comb begin
    xx1_nxt   = SQ_W'(32'(in_data.target_x) * 32'(in_data.target_x));
    yy1_nxt   = SQ_W'(32'(in_data.target_y) * 32'(in_data.target_y));
    l1sq1_nxt = LSQ_W'(l1) * LSQ_W'(l1);
    l2sq1_nxt = LSQ_W'(l2) * LSQ_W'(l2);
    l12_1_nxt = LSQ_W'(l1) * LSQ_W'(l2);

    r2_2_nxt = R2_W'(xx1_r) + R2_W'(yy1_r);
    ll2_nxt  = BOT_W'(l1sq1_r) + BOT_W'(l2sq1_r);
    bot2_nxt = {l12_1_r, 1'b0};

    top3_nxt = signed'(TOPR_W'(ll2_r)) - signed'(TOPR_W'(r2_2_r));

    bnd = signed'(TOPR_W'(bot3_r));
    side4_nxt.x       = x3_r;
    side4_nxt.y       = y3_r;
    side4_nxt.bottom  = bot3_r;
    side4_nxt.unreach = 1'b1;
    if (top3_r > bnd) begin
      side4_nxt.top = TOP_W'(bnd);
    end else if (top3_r < -bnd) begin
      side4_nxt.top = TOP_W'(-bnd);
    end else begin
      side4_nxt.top     = TOP_W'(top3_r);
      side4_nxt.unreach = 1'b0;
    end

    bm5_nxt = TOP_W'(signed'(TOPR_W'(side4_r.bottom)) - TOPR_W'(side4_r.top));
    bp5_nxt = TOP_W'(signed'(TOPR_W'(side4_r.bottom)) + TOPR_W'(side4_r.top));

    rad6_nxt = RAD_W'(PROD_W'(bm5_r) * PROD_W'(bp5_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r;     v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_data.target_x; y1_r <= in_data.target_y;
      xx1_r <= xx1_nxt; yy1_r <= yy1_nxt;
      l1sq1_r <= l1sq1_nxt; l2sq1_r <= l2sq1_nxt; l12_1_r <= l12_1_nxt;
      x2_r <= x1_r; y2_r <= y1_r;
      r2_2_r <= r2_2_nxt; ll2_r <= ll2_nxt; bot2_r <= bot2_nxt;
      x3_r <= x2_r; y3_r <= y2_r;
      top3_r <= top3_nxt; bot3_r <= bot2_r;
      side4_r <= side4_nxt;
      side5_r <= side4_r; bm5_r <= bm5_nxt; bp5_r <= bp5_nxt;
      side6_r <= side5_r; rad6_r <= rad6_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_rad   = rad6_r;
  assign out_side  = side6_r;

endmodule
`default_nettype wire

[rtl/core/tlik_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module tlik_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tlik_pkg::RAD_W-1:0]    in_rad,
  input  tlik_pkg::tlik_side_t          in_side,
  output logic                          out_valid,
  output logic [tlik_pkg::SQRT_W-1:0]   out_root,
  output tlik_pkg::tlik_side_t          out_side
);
  import tlik_pkg::*;

  localparam int TW = RAD_W + 1;

  logic             vld_r  [SQRT_W];
  logic [RAD_W-1:0] rem_r  [SQRT_W];
  logic [SQRT_W-1:0] q_r   [SQRT_W];
  tlik_side_t       side_r [SQRT_W];

  for (genvar g = 0; g < SQRT_W; g++) begin : g_stage
    localparam int Pos = SQRT_W - 1 - g;
    logic              vld_in;
    logic [RAD_W-1:0]  rem_in, rem_nxt;
    logic [SQRT_W-1:0] q_in, q_nxt;
    tlik_side_t        side_in;
    logic [TW-1:0]     trial;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rad;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign q_in    = q_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      trial = (TW'(q_in) << (Pos + 1)) + (TW'(1) << (2 * Pos));
      if (TW'(rem_in) >= trial) begin
        rem_nxt = RAD_W'(TW'(rem_in) - trial);
        q_nxt   = q_in | (SQRT_W'(1) << Pos);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        q_r[g]    <= q_nxt;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[SQRT_W-1];
  assign out_root  = q_r[SQRT_W-1];
  assign out_side  = side_r[SQRT_W-1];

endmodule
`default_nettype wire

[rtl/core/tlik_vec.sv]
// Pipelined vectoring CORDIC: quadrant fold, normalize, rotate; angle in Q4.30.
`default_nettype none
module tlik_vec (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [tlik_pkg::VEC_W-1:0]   in_x,
  input  logic signed [tlik_pkg::VEC_W-1:0]   in_y,
  input  logic                                in_ovr,
  input  logic signed [tlik_pkg::ANG_W-1:0]   in_ovr_val,
  output logic                                out_valid,
  output logic signed [tlik_pkg::ANG_W-1:0]   out_angle
);
  import tlik_pkg::*;

  localparam int NST = 1 + NORM_STEPS + CORDIC_STAGES;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    frc;
    logic signed [ANG_W-1:0] fval;
  } tlik_vst_t;

  logic      vld_r [NST];
  tlik_vst_t st_r  [NST];

  // quadrant fold; in_ovr forces in_ovr_val, zero vector forced to 0
  tlik_vst_t pre_nxt;
  always_comb begin
    pre_nxt.frc  = in_ovr | ((in_x == '0) && (in_y == '0));
    pre_nxt.fval = in_ovr ? in_ovr_val : '0;
    pre_nxt.x    = in_x;
    pre_nxt.y    = in_y;
    pre_nxt.z    = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        pre_nxt.z = HALF_PI;
        pre_nxt.x = in_y;
        pre_nxt.y = -in_x;
      end else begin
        pre_nxt.z = -HALF_PI;
        pre_nxt.x = -in_y;
        pre_nxt.y = in_x;
      end
    end
  end

  for (genvar g = 0; g < NST; g++) begin : g_stage
    tlik_vst_t st_nxt;
    if (g == 0) begin : g_pre
      assign st_nxt = pre_nxt;
    end else if (g <= NORM_STEPS) begin : g_norm
      localparam int Sh = 1 << (NORM_STEPS - g);
      localparam logic signed [VEC_W-1:0] Lim  = VEC_W'(1) << (NORM_BIT + 1 - Sh);
      localparam logic signed [VEC_W-1:0] NLim = -Lim;
      tlik_vst_t s;
      assign s = st_r[g-1];
      always_comb begin
        st_nxt = s;
        if ((s.x > NLim) && (s.x < Lim) && (s.y > NLim) && (s.y < Lim)) begin
          st_nxt.x = s.x <<< Sh;
          st_nxt.y = s.y <<< Sh;
        end
      end
    end else begin : g_rot
      localparam int I = g - 1 - NORM_STEPS;
      tlik_vst_t s;
      logic signed [VEC_W-1:0] dx, dy;
      assign s  = st_r[g-1];
      assign dx = s.y >>> I;
      assign dy = s.x >>> I;
      always_comb begin
        st_nxt = s;
        if (s.y >= 0) begin
          st_nxt.x = s.x + dx;
          st_nxt.y = s.y - dy;
          st_nxt.z = s.z + atan_q30(I);
        end else begin
          st_nxt.x = s.x - dx;
          st_nxt.y = s.y + dy;
          st_nxt.z = s.z - atan_q30(I);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= (g == 0) ? in_valid : vld_r[(g == 0) ? 0 : g - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_angle = st_r[NST-1].frc ? st_r[NST-1].fval : st_r[NST-1].z;

endmodule
`default_nettype wire

[rtl/core/two_link_planar_ik.sv]
// Top level: two-link planar inverse kinematics pipeline.
//
// Input channel in_valid/in_stall/in_data carries a target (x, y) in signed
// Q8.8; output channel out_valid/out_stall/out_data gives shoulder angle
// (signed Q3.13), elbow angle (Q2.13, 0..pi) and an unreachable flag.
// One transfer in gives exactly one transfer out, in order.
// The pipeline has 6 front stages, 29 square-root stages, 3 operand
// stages, 7 + CORDIC_STAGES stages in each of the three parallel CORDIC
// units and 2 rounding stages.
// Throughput is one target per cycle unless out_stall freezes the pipeline;
// every stage is registered. Link lengths are written through
// cfg_we/cfg_index/cfg_wdata and must only change while no target is in
// flight; reset loads 30 cm and 40 cm. Reset (rst_n low, synchronous)
// clears all valid bits. When out_stall is held with a result waiting, the
// whole pipeline freezes and in_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module two_link_planar_ik (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tlik_pkg::tlik_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tlik_pkg::tlik_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlik_pkg::LEN_W-1:0]           cfg_wdata
);
  import tlik_pkg::*;

  logic adv;
  logic [LEN_W-1:0] l1_r, l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= L1_RESET;
      l2_r <= L2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: l1_r <= cfg_wdata;
        REG_LOWER: l2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic              fr_valid, sq_valid;
  logic [RAD_W-1:0]  fr_rad;
  tlik_side_t        fr_side, sq_side;
  logic [SQRT_W-1:0] sq_root;

  tlik_front u_front (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(in_valid), .in_data(in_data), .l1(l1_r), .l2(l2_r),
    .out_valid(fr_valid), .out_rad(fr_rad), .out_side(fr_side)
  );

  tlik_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(fr_valid), .in_rad(fr_rad), .in_side(fr_side),
    .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
  );

  // stage A: shoulder operand products
  logic vA_r, vB_r, vC_r;
  tlik_side_t sideA_r, sideB_r;
  logic [SQRT_W-1:0] sA_r, sB_r;
  logic [NUM_W-1:0]  numA_r, numA_nxt, numB_r;
  logic [P1_W-1:0]   p1A_r, p1A_nxt;
  logic signed [P2_W-1:0]  p2A_r, p2A_nxt;
  logic signed [DEN_W-1:0] denB_r, denB_nxt;

  always_comb begin
    numA_nxt = NUM_W'(l2_r) * NUM_W'(sq_root);
    p1A_nxt  = P1_W'(l1_r) * P1_W'(sq_side.bottom);
    p2A_nxt  = P2_W'(signed'({1'b0, l2_r})) * P2_W'(sq_side.top);
    denB_nxt = DEN_W'(signed'({1'b0, p1A_r})) - DEN_W'(p2A_r);
  end

  // stage C: CORDIC operand vectors
  logic signed [VEC_W-1:0] ax_r, ay_r, bx_r, by_r, tx_r, ty_r;
  logic signed [VEC_W-1:0] tx_nxt, ty_nxt, numv, denv;
  logic tovr_r, tovr_nxt, unrC_r;
  logic signed [ANG_W-1:0] tval_r, tval_nxt;

  always_comb begin
    numv     = signed'(VEC_W'(numB_r));
    denv     = VEC_W'(denB_r);
    tovr_nxt = (denB_r == '0);
    tval_nxt = (numB_r != '0) ? HALF_PI : '0;
    if (denB_r < 0) begin
      tx_nxt = -denv;
      ty_nxt = -numv;
    end else begin
      tx_nxt = denv;
      ty_nxt = numv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0; vB_r <= 1'b0; vC_r <= 1'b0;
    end else if (adv) begin
      vA_r <= sq_valid; vB_r <= vA_r; vC_r <= vB_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sideA_r <= sq_side; sA_r <= sq_root;
      numA_r <= numA_nxt; p1A_r <= p1A_nxt; p2A_r <= p2A_nxt;
      sideB_r <= sideA_r; sB_r <= sA_r; numB_r <= numA_r; denB_r <= denB_nxt;
      ax_r <= VEC_W'(sideB_r.x);
      ay_r <= VEC_W'(sideB_r.y);
      bx_r <= VEC_W'(sideB_r.top);
      by_r <= signed'(VEC_W'(sB_r));
      tx_r <= tx_nxt; ty_r <= ty_nxt;
      tovr_r <= tovr_nxt; tval_r <= tval_nxt;
      unrC_r <= sideB_r.unreach;
    end
  end

  logic va, vb, vt;
  logic signed [ANG_W-1:0] za, zb, zt;

  tlik_vec u_vec_alfa (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vC_r),
    .in_x(ax_r), .in_y(ay_r), .in_ovr(1'b0), .in_ovr_val('0),
    .out_valid(va), .out_angle(za)
  );

  tlik_vec u_vec_beta (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vC_r),
    .in_x(bx_r), .in_y(by_r), .in_ovr(1'b0), .in_ovr_val('0),
    .out_valid(vb), .out_angle(zb)
  );

  tlik_vec u_vec_theta (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vC_r),
    .in_x(tx_r), .in_y(ty_r), .in_ovr(tovr_r), .in_ovr_val(tval_r),
    .out_valid(vt), .out_angle(zt)
  );

  // unreachable flag rides alongside the CORDIC units
  logic unr_dl_r [VEC_LAT];
  for (genvar g = 0; g < VEC_LAT; g++) begin : g_unr
    always_ff @(posedge clk) begin
      if (adv) begin
        unr_dl_r[g] <= (g == 0) ? unrC_r : unr_dl_r[(g == 0) ? 0 : g - 1];
      end
    end
  end

  // stage D: elbow rounding, shoulder difference
  logic vD_r, unrD_r;
  logic [14:0] elbowD_r, elbowD_nxt;
  logic signed [ANG_W:0] diffD_r, diffD_nxt, esum, eshr;

  always_comb begin
    esum = (ANG_W + 1)'(zb) + ROUND_HALF;
    eshr = esum >>> ANG_SHIFT;
    if (eshr < 0) begin
      elbowD_nxt = '0;
    end else if (eshr > ELBOW_MAX) begin
      elbowD_nxt = 15'(ELBOW_MAX);
    end else begin
      elbowD_nxt = 15'(eshr);
    end
    diffD_nxt = (ANG_W + 1)'(za) - (ANG_W + 1)'(zt);
  end

  // stage E: shoulder rounding into the output register
  logic out_valid_r;
  tlik_out_t out_r, out_nxt;
  logic signed [ANG_W:0] ssum, sshr;

  always_comb begin
    ssum = diffD_r + ROUND_HALF;
    sshr = ssum >>> ANG_SHIFT;
    if (sshr < SHLD_MIN) begin
      out_nxt.shoulder_angle = 16'(SHLD_MIN);
    end else if (sshr > SHLD_MAX) begin
      out_nxt.shoulder_angle = 16'(SHLD_MAX);
    end else begin
      out_nxt.shoulder_angle = 16'(sshr);
    end
    out_nxt.elbow_angle = elbowD_r;
    out_nxt.unreachable = unrD_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vD_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vD_r        <= va & vb & vt;
      out_valid_r <= vD_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      elbowD_r <= elbowD_nxt;
      diffD_r  <= diffD_nxt;
      unrD_r   <= unr_dl_r[VEC_LAT-1];
      out_r    <= out_nxt;
    end
  end

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
